// ===== rtl/tsr_pkg.sv =====
// Shared types, codes and helpers for the TCP segment reassembly core.
package tsr_pkg;

  // Default number of out-of-order table slots.
  localparam int unsigned QueueDepthDefault = 8;

  // Reset value of the receive window register.
  localparam logic [15:0] WindowReset = 16'hFFFF;

  // Result codes.
  typedef enum logic [1:0] {
    ACT_DELIVER     = 2'd0,
    ACT_QUEUED      = 2'd1,
    ACT_DROP_WINDOW = 2'd2,
    ACT_DROP_FULL   = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_RECEIVE_WINDOW   = 1'b0,
    CFG_INITIAL_SEQUENCE = 1'b1
  } cfg_reg_e;

  // One received segment descriptor.
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] seg_len;
    logic        fin;
    logic [7:0]  buffer_tag;
  } seg_in_t;

  // One result word.
  typedef struct packed {
    action_e     action;
    logic [7:0]  out_tag;
    logic [31:0] out_seq;
    logic [15:0] out_len;
    logic        out_fin;
    logic [31:0] next_expected;
    logic        send_ack;
    logic        start_delack;
    logic        last;
  } seg_out_t;

  // One out-of-order table entry.
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
    logic [7:0]  tag;
  } entry_t;

  // Operations broadcast to the row of table cells.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INSERT,
    OP_SCAN_KEEP,
    OP_SCAN_DROP
  } cell_op_e;

  // Broadcast control for the cell row.
  typedef struct packed {
    cell_op_e op;
    entry_t   data;
  } cell_ctrl_t;

  // Serial-number order: a comes before b when (a - b) is negative mod 2^32.
  function automatic logic serial_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

endpackage

// ===== rtl/tcp_segment_reassembly_core.sv =====
// Top level of the TCP segment reassembly core: control sequencer and cell row.
//
//   channel   direction  handshake                  payload
//   in        in         in_valid_i / in_ready_o    in_i  (tsr_pkg::seg_in_t)
//   out       out        out_valid_o / out_ready_i  out_o (tsr_pkg::seg_out_t)
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A segment is taken only while idle and decided in the next cycle; a dropped segment
// then goes to its final word, a queued one is inserted first, and a delivery scans the
// table, one entry per cycle unless a head waits for output, before returning to idle.
// Each delivered word and the final word wait for the output register to be free.
// Reset empties the table, sets the window to 65535 and the expected sequence to 0.
// The configuration port is always ready and is meant to be written while idle.
module tcp_segment_reassembly_core #(
  parameter int unsigned QUEUE_DEPTH = tsr_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tsr_pkg::seg_in_t    in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsr_pkg::seg_out_t   out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INSERT,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e              state_q;
  tsr_pkg::seg_in_t    in_q;
  tsr_pkg::seg_out_t   pend_q;
  tsr_pkg::seg_out_t   out_q;
  logic                out_valid_q;
  logic [31:0]         next_seq_q;
  logic [15:0]         window_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       step_q;
  logic [CW-1:0]       drop_q;

  tsr_pkg::cell_ctrl_t cell_ctrl;
  tsr_pkg::entry_t     ent_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found_w;
  logic [CW-1:0]       wr_idx;

  tsr_pkg::entry_t     head;
  tsr_pkg::entry_t     in_ent;
  logic                head_hit;
  logic                scan_done;
  logic                out_free;
  logic                out_load;
  logic [31:0]         head_ns;
  logic [31:0]         in_ns;
  tsr_pkg::seg_out_t   res_in;
  tsr_pkg::seg_out_t   res_dec;
  tsr_pkg::seg_out_t   res_fin;
  tsr_pkg::seg_out_t   res_head;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Scan datapath: the head cell is checked against the expected sequence.
  assign head      = ent_w[0];
  assign head_hit  = (head.seq == next_seq_q);
  assign scan_done = (step_q == count_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign head_ns   = next_seq_q + 32'(head.len) + 32'(head.fin);
  assign in_ns     = next_seq_q + 32'(in_q.seg_len) + 32'(in_q.fin);
  assign wr_idx    = count_q - drop_q - CW'(1);

  // The output register takes a word on a delivered head or on the final word.
  assign out_load = ((state_q == S_SCAN) && !scan_done && head_hit && out_free) ||
                    ((state_q == S_EMIT) && out_free);

  assign in_ent.seq = in_q.seq;
  assign in_ent.len = in_q.seg_len;
  assign in_ent.fin = in_q.fin;
  assign in_ent.tag = in_q.buffer_tag;

  // Result words for the incoming segment and for a delivered table head.
  always_comb begin
    res_in               = '0;
    res_in.action        = tsr_pkg::ACT_QUEUED;
    res_in.out_tag       = in_q.buffer_tag;
    res_in.out_seq       = in_q.seq;
    res_in.out_len       = in_q.seg_len;
    res_in.next_expected = next_seq_q;

    res_head               = '0;
    res_head.action        = tsr_pkg::ACT_DELIVER;
    res_head.out_tag       = head.tag;
    res_head.out_seq       = head.seq;
    res_head.out_len       = head.len;
    res_head.out_fin       = head.fin;
    res_head.next_expected = head_ns;
  end

  // Decision on the incoming segment, and the final word built from the held one.
  always_comb begin
    res_dec = res_in;
    if (window_q == '0) begin
      res_dec.action = tsr_pkg::ACT_DROP_WINDOW;
    end else if (in_q.seq == next_seq_q) begin
      res_dec.action        = tsr_pkg::ACT_DELIVER;
      res_dec.out_fin       = in_q.fin;
      res_dec.next_expected = in_ns;
    end else if (count_q == CW'(QUEUE_DEPTH)) begin
      res_dec.action = tsr_pkg::ACT_DROP_FULL;
    end else begin
      res_dec.send_ack = 1'b1;
    end

    res_fin              = pend_q;
    res_fin.last         = 1'b1;
    res_fin.start_delack = (pend_q.action == tsr_pkg::ACT_DELIVER);
  end

  // Operation broadcast to the cell row.
  always_comb begin
    cell_ctrl.data = in_ent;
    cell_ctrl.op   = tsr_pkg::OP_HOLD;
    unique case (state_q)
      S_DECIDE: cell_ctrl.op = tsr_pkg::OP_CMP;
      S_INSERT: cell_ctrl.op = tsr_pkg::OP_INSERT;
      S_SCAN: begin
        cell_ctrl.data = head;
        if (!scan_done) begin
          if (!head_hit) begin
            cell_ctrl.op = tsr_pkg::OP_SCAN_KEEP;
          end else if (out_free) begin
            cell_ctrl.op = tsr_pkg::OP_SCAN_DROP;
          end
        end
      end
      default: cell_ctrl.op = tsr_pkg::OP_HOLD;
    endcase
  end

  // Row of table cells.
  assign found_w[0] = 1'b0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    tsr_pkg::entry_t left_w;
    tsr_pkg::entry_t right_w;

    if (k == 0) begin : g_first
      assign left_w = in_ent;
    end else begin : g_mid
      assign left_w = ent_w[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign right_w = ent_w[k];
    end else begin : g_body
      assign right_w = ent_w[k+1];
    end

    tsr_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .live_i   (CW'(k) < count_q),
      .wr_hit_i (wr_idx == CW'(k)),
      .found_i  (found_w[k]),
      .left_i   (left_w),
      .right_i  (right_w),
      .found_o  (found_w[k+1]),
      .ent_o    (ent_w[k])
    );
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_q        <= '0;
      pend_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      next_seq_q  <= '0;
      window_q    <= tsr_pkg::WindowReset;
      count_q     <= '0;
      step_q      <= '0;
      drop_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (tsr_pkg::cfg_reg_e'(cfg_index_i))
          tsr_pkg::CFG_RECEIVE_WINDOW:   window_q <= cfg_data_i[15:0];
          tsr_pkg::CFG_INITIAL_SEQUENCE: next_seq_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_i;
            state_q <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          pend_q <= res_dec;
          if (window_q == '0) begin
            state_q <= S_EMIT;
          end else if (in_q.seq == next_seq_q) begin
            next_seq_q <= in_ns;
            step_q     <= '0;
            drop_q     <= '0;
            state_q    <= S_SCAN;
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_INSERT;
          end
        end

        S_INSERT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_EMIT;
        end

        S_SCAN: begin
          if (scan_done) begin
            count_q <= count_q - drop_q;
            state_q <= S_EMIT;
          end else if (!head_hit) begin
            step_q <= step_q + CW'(1);
          end else if (out_free) begin
            // A later delivery exists, so the held one is not the final word.
            out_q      <= pend_q;
            pend_q     <= res_head;
            next_seq_q <= head_ns;
            step_q     <= step_q + CW'(1);
            drop_q     <= drop_q + CW'(1);
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_q   <= res_fin;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("table count exceeds depth");

  // During a scan, removals never outrun the entries already visited.
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (drop_q <= step_q) && (step_q <= count_q))
    else $error("scan counters out of order");

  // A queued segment always requests an ACK and ends its input.
  a_queued_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.action == tsr_pkg::ACT_QUEUED) |->
      (out_q.send_ack && out_q.last))
    else $error("queued result without ack or last");

  // The delayed ACK timer starts only on the final word of a delivery run.
  a_delack_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.start_delack) |->
      (out_q.last && out_q.action == tsr_pkg::ACT_DELIVER))
    else $error("delayed ack on a non-final or non-delivery word");

endmodule

// ===== rtl/tsr_cell.sv =====
// One slot of the out-of-order table, linked to its left and right neighbors.
module tsr_cell (
  input  logic                clk_i,
  input  tsr_pkg::cell_ctrl_t ctrl_i,
  input  logic                live_i,
  input  logic                wr_hit_i,
  input  logic                found_i,
  input  tsr_pkg::entry_t     left_i,
  input  tsr_pkg::entry_t     right_i,
  output logic                found_o,
  output tsr_pkg::entry_t     ent_o
);

  tsr_pkg::entry_t ent_q;
  logic            flag_q;

  // The insert point is the first slot whose flag is set; the chain carries it right.
  assign found_o = found_i | flag_q;
  assign ent_o   = ent_q;

  // Slot update: compare, insert with shift right, or scan with shift left.
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      tsr_pkg::OP_CMP: begin
        flag_q <= !live_i || tsr_pkg::serial_before(ctrl_i.data.seq, ent_q.seq);
      end
      tsr_pkg::OP_INSERT: begin
        if (found_i) begin
          ent_q <= left_i;
        end else if (flag_q) begin
          ent_q <= ctrl_i.data;
        end
      end
      tsr_pkg::OP_SCAN_KEEP: begin
        ent_q <= wr_hit_i ? ctrl_i.data : right_i;
      end
      tsr_pkg::OP_SCAN_DROP: begin
        ent_q <= right_i;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/sv/tcp_segment_reassembly_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the TCP segment reassembly core, checked word by word against an in-bench model.
module tcp_segment_reassembly_core_tb;

  localparam int unsigned QDEPTH        = tsr_pkg::QueueDepthDefault;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  tsr_pkg::seg_in_t   in_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  tsr_pkg::seg_out_t  out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = tsr_pkg::CFG_RECEIVE_WINDOW;
  logic [31:0]        cfg_data_i  = '0;

  // Reassembly model state: receive window, next expected sequence and the sorted table.
  logic [15:0]        rcv_wnd   = tsr_pkg::WindowReset;
  logic [31:0]        rcv_nxt   = '0;
  tsr_pkg::entry_t    ooo_table [QDEPTH];
  int unsigned        ooo_count = 0;

  // Outcome words predicted but not yet seen on the output channel.
  tsr_pkg::seg_out_t  pending_outcomes [$];

  int unsigned error_count     = 0;
  int unsigned segments_sent   = 0;
  int unsigned configs_written = 0;
  int unsigned words_by_action [4];
  int unsigned cycle_count     = 0;
  int unsigned ready_hold      = 0;
  int unsigned stall_left      = 0;
  bit          idle_on         = 1'b1;

  tcp_segment_reassembly_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs or loses a word.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d outcome words outstanding", $time,
               pending_outcomes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Builds one outcome word; next_expected is the model's sequence at this point.
  function automatic tsr_pkg::seg_out_t outcome_word(tsr_pkg::action_e act, logic [7:0] tag,
                                                     logic [31:0] seq, logic [15:0] len,
                                                     logic fin, logic ack);
    tsr_pkg::seg_out_t w;
    w               = '0;
    w.action        = act;
    w.out_tag       = tag;
    w.out_seq       = seq;
    w.out_len       = len;
    w.out_fin       = fin;
    w.next_expected = rcv_nxt;
    w.send_ack      = ack;
    return w;
  endfunction

  // Applies one accepted segment to the model and queues the words it must produce.
  function automatic void reassemble_segment(tsr_pkg::seg_in_t s);
    tsr_pkg::seg_out_t w;
    int unsigned       idx;
    int unsigned       keep;
    int unsigned       pos;
    logic [31:0]       diff;
    if (rcv_wnd == 16'd0) begin
      w = outcome_word(tsr_pkg::ACT_DROP_WINDOW, s.buffer_tag, s.seq, s.seg_len,
                       1'b0, 1'b0);
      w.last = 1'b1;
      pending_outcomes.push_back(w);
    end else if (s.seq == rcv_nxt) begin
      // In order: deliver it, then one pass over the table picks up what now fits.
      rcv_nxt = rcv_nxt + s.seg_len + s.fin;
      w = outcome_word(tsr_pkg::ACT_DELIVER, s.buffer_tag, s.seq, s.seg_len, s.fin, 1'b0);
      keep = 0;
      for (idx = 0; idx < ooo_count; idx++) begin
        if (ooo_table[idx].seq == rcv_nxt) begin
          pending_outcomes.push_back(w);
          rcv_nxt = rcv_nxt + ooo_table[idx].len + ooo_table[idx].fin;
          w = outcome_word(tsr_pkg::ACT_DELIVER, ooo_table[idx].tag, ooo_table[idx].seq,
                           ooo_table[idx].len, ooo_table[idx].fin, 1'b0);
        end else begin
          ooo_table[keep] = ooo_table[idx];
          keep++;
        end
      end
      ooo_count = keep;
      w.start_delack = 1'b1;
      w.last         = 1'b1;
      pending_outcomes.push_back(w);
    end else if (ooo_count >= QDEPTH) begin
      w = outcome_word(tsr_pkg::ACT_DROP_FULL, s.buffer_tag, s.seq, s.seg_len, 1'b0, 1'b0);
      w.last = 1'b1;
      pending_outcomes.push_back(w);
    end else begin
      // Out of order: insert in serial-number order, after any equal sequence.
      pos = 0;
      while (pos < ooo_count) begin
        diff = s.seq - ooo_table[pos].seq;
        if (diff[31]) break;
        pos++;
      end
      for (idx = ooo_count; idx > pos; idx--) ooo_table[idx] = ooo_table[idx - 1];
      ooo_table[pos].seq = s.seq;
      ooo_table[pos].len = s.seg_len;
      ooo_table[pos].fin = s.fin;
      ooo_table[pos].tag = s.buffer_tag;
      ooo_count++;
      w = outcome_word(tsr_pkg::ACT_QUEUED, s.buffer_tag, s.seq, s.seg_len, 1'b0, 1'b1);
      w.last = 1'b1;
      pending_outcomes.push_back(w);
    end
  endfunction

  task automatic check_field(input string label, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want_v, got_v);
      error_count++;
    end
  endtask

  // Compares every accepted output word with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    tsr_pkg::seg_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %h", $time, out_o);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("action", 32'(want.action), 32'(out_o.action));
        check_field("out_tag", 32'(want.out_tag), 32'(out_o.out_tag));
        check_field("out_seq", want.out_seq, out_o.out_seq);
        check_field("out_len", 32'(want.out_len), 32'(out_o.out_len));
        check_field("out_fin", 32'(want.out_fin), 32'(out_o.out_fin));
        check_field("next_expected", want.next_expected, out_o.next_expected);
        check_field("send_ack", 32'(want.send_ack), 32'(out_o.send_ack));
        check_field("start_delack", 32'(want.start_delack), 32'(out_o.start_delack));
        check_field("last", 32'(want.last), 32'(out_o.last));
        words_by_action[int'(want.action)]++;
      end
    end
  end

  // Output ready: a long hold-off on request, otherwise random stall bursts while idle_on is set.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offers one segment and waits for it to be taken. Valid stays high for the next call.
  task automatic send_segment(input logic [31:0] seq, input logic [15:0] len,
                              input logic fin, input logic [7:0] tag);
    tsr_pkg::seg_in_t s;
    int unsigned      gap;
    s.seq        = seq;
    s.seg_len    = len;
    s.fin        = fin;
    s.buffer_tag = tag;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= s;
    do @(posedge clk_i); while (!in_ready_o);
    reassemble_segment(s);
    segments_sent++;
  endtask

  // Drops the input valid and waits until the core has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input tsr_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tsr_pkg::CFG_RECEIVE_WINDOW) begin
      rcv_wnd = data[15:0];
    end else begin
      rcv_nxt = data;
    end
    configs_written++;
  endtask

  // Writes the window (upper data bits random) and optionally reloads the expected sequence.
  task automatic configure(input logic [15:0] window, input bit load_seq,
                           input logic [31:0] isn);
    settle();
    write_config(tsr_pkg::CFG_RECEIVE_WINDOW, {16'($urandom_range(0, 65535)), window});
    if (load_seq) write_config(tsr_pkg::CFG_INITIAL_SEQUENCE, isn);
    cfg_valid_i <= 1'b0;
  endtask

  // Empties the table by placing the expected sequence just ahead of its head entry.
  task automatic flush_table();
    logic [31:0] head;
    while (ooo_count != 0) begin
      head = ooo_table[0].seq - 32'd1;
      configure(rcv_wnd == 16'd0 ? tsr_pkg::WindowReset : rcv_wnd, 1'b1, head);
      send_segment(head, 16'd1, 1'b0, 8'($urandom_range(0, 255)));
    end
    settle();
  endtask

  // Mostly short payloads, with empty and very long ones mixed in.
  function automatic logic [15:0] segment_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'($urandom_range(0, 65535));
    if (r < 23) return 16'hFFFF;
    return 16'($urandom_range(1, 64));
  endfunction

  // Contiguous runs of segments in scrambled order, plus stray and duplicate segments.
  task automatic run_segment_mix(input int unsigned n_items);
    tsr_pkg::seg_in_t burst [$];
    tsr_pkg::seg_in_t tmp;
    int unsigned      start_cnt;
    int unsigned      n_seg;
    int unsigned      j;
    int unsigned      pick;
    logic [31:0]      cursor;
    start_cnt = segments_sent;
    while (segments_sent - start_cnt < n_items) begin
      burst.delete();
      if ($urandom_range(0, 99) < 20) begin
        case ($urandom_range(0, 3))
          0:       tmp.seq = $urandom();
          1:       tmp.seq = rcv_nxt + $urandom_range(1, 3000);
          2:       tmp.seq = rcv_nxt - $urandom_range(1, 3000);
          default: tmp.seq = rcv_nxt;
        endcase
        tmp.seg_len    = segment_length();
        tmp.fin        = ($urandom_range(0, 7) == 0);
        tmp.buffer_tag = 8'($urandom_range(0, 255));
        burst.push_back(tmp);
      end else begin
        n_seg  = $urandom_range(1, QDEPTH + 1);
        cursor = rcv_nxt;
        for (j = 0; j < n_seg; j++) begin
          tmp.seq        = cursor;
          tmp.seg_len    = segment_length();
          tmp.fin        = (j == n_seg - 1) && ($urandom_range(0, 3) == 0);
          tmp.buffer_tag = 8'($urandom_range(0, 255));
          cursor         = cursor + tmp.seg_len + tmp.fin;
          burst.push_back(tmp);
        end
        // Scramble the arrival order.
        for (j = n_seg - 1; j > 0; j--) begin
          pick        = $urandom_range(0, j);
          tmp         = burst[j];
          burst[j]    = burst[pick];
          burst[pick] = tmp;
        end
      end
      foreach (burst[k]) begin
        send_segment(burst[k].seq, burst[k].seg_len, burst[k].fin, burst[k].buffer_tag);
      end
      if (rcv_wnd != 16'd0 && ooo_count >= QDEPTH - 2 && $urandom_range(0, 2) == 0) begin
        flush_table();
      end
    end
  endtask

  // Hand-picked segments: ordering, equal sequences, stale entries, wrap, full table.
  task automatic test_directed();
    int unsigned k;
    // In-order delivery from the reset state.
    send_segment(32'd0, 16'd100, 1'b0, 8'h01);
    // Out-of-order arrivals, two with the same sequence; the empty one goes stale.
    send_segment(32'd300, 16'd50, 1'b0, 8'h02);
    send_segment(32'd200, 16'd100, 1'b0, 8'h03);
    send_segment(32'd200, 16'd0, 1'b0, 8'h04);
    send_segment(32'd100, 16'd100, 1'b0, 8'h05);
    // A bare FIN, then the largest payload with FIN.
    send_segment(32'd350, 16'd0, 1'b1, 8'h06);
    send_segment(32'd351, 16'hFFFF, 1'b1, 8'hFF);
    send_segment(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'h00);
    flush_table();
    // Sequence space wrapping through zero.
    configure(16'hFFFF, 1'b1, 32'hFFFF_FFF0);
    send_segment(32'h0000_0010, 16'd8, 1'b0, 8'h07);
    send_segment(32'hFFFF_FFF8, 16'h0018, 1'b0, 8'h08);
    send_segment(32'hFFFF_FFF0, 16'd8, 1'b0, 8'h09);
    // Fill the table, overflow it, then release the whole chain at once.
    configure(16'd1, 1'b1, 32'h8000_0000);
    for (k = 1; k <= QDEPTH; k++) begin
      send_segment(32'h8000_0000 + 10 * k, 16'd10, k == QDEPTH, 8'(8'h10 + k));
    end
    send_segment(32'h8000_1000, 16'd1, 1'b0, 8'hEE);
    send_segment(32'h8000_0000, 16'd10, 1'b0, 8'h10);
    // Closed window drops even the expected segment.
    configure(16'd0, 1'b1, 32'h0000_0000);
    send_segment(32'h0000_0000, 16'd5, 1'b1, 8'hA5);
    send_segment(32'h1234_5678, 16'd9, 1'b0, 8'h5A);
    configure(16'hFFFF, 1'b0, '0);
  endtask

  task automatic test_random_reassembly();
    run_segment_mix(140);
  endtask

  // Several window and start-sequence settings, the extremes among them.
  task automatic test_window_settings();
    int unsigned k;
    configure(16'd1, 1'b1, 32'hFFFF_FFFF);
    run_segment_mix(20);
    configure(16'd0, 1'b0, '0);
    run_segment_mix(8);
    for (k = 0; k < 3; k++) begin
      configure(16'($urandom_range(1, 65535)), 1'b1, $urandom());
      run_segment_mix(12);
    end
    configure(16'hFFFF, 1'b1, 32'h0000_0000);
  endtask

  // The receiver holds off for a long stretch while segments keep coming.
  task automatic test_output_backpressure();
    ready_hold = 400;
    run_segment_mix(40);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    run_segment_mix(100);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_reassembly();
    test_window_settings();
    test_output_backpressure();
    test_full_rate();
    settle();
    $display("Sent %0d segments and %0d register writes across ordered, scrambled, wrapped,",
             segments_sent, configs_written);
    $display("closed-window and full-table traffic; words seen: %0d delivered, %0d queued, %0d %s",
             words_by_action[0], words_by_action[1],
             words_by_action[2] + words_by_action[3], "dropped");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
